[rtl/nccs_pkg.sv]
package nccs_pkg;

    localparam logic [7:0] CMD_READ0       = 8'h00;
    localparam logic [7:0] CMD_READ1       = 8'h01;
    localparam logic [7:0] CMD_RNDOUT      = 8'h05;
    localparam logic [7:0] CMD_PAGEPROG    = 8'h10;
    localparam logic [7:0] CMD_CACHEDPROG  = 8'h15;
    localparam logic [7:0] CMD_READSTART   = 8'h30;
    localparam logic [7:0] CMD_READOOB     = 8'h50;
    localparam logic [7:0] CMD_ERASE1      = 8'h60;
    localparam logic [7:0] CMD_STATUS      = 8'h70;
    localparam logic [7:0] CMD_SEQIN       = 8'h80;
    localparam logic [7:0] CMD_RNDIN       = 8'h85;
    localparam logic [7:0] CMD_ERASE2      = 8'hD0;
    localparam logic [7:0] CMD_RNDOUTSTART = 8'hE0;

    localparam logic [15:0] HALF_POINTER         = 16'd256;
    localparam logic [3:0]  SMALL_PAGE_SHIFT_MAX = 4'd9;
    localparam logic [5:0]  SMALL_THIRD_BITS     = 6'd25;
    localparam logic [5:0]  LARGE_THIRD_BITS     = 6'd27;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHIP_KNOWN  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_SHIFT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHIP_SHIFT  = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_WAIT_READY = 2'd0,
        KIND_COMMAND    = 2'd1,
        KIND_ADDRESS    = 2'd2,
        KIND_WAIT_DONE  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_READY = 4'd0,
        PH_PTR   = 4'd1,
        PH_CMD   = 4'd2,
        PH_COL0  = 4'd3,
        PH_COL1  = 4'd4,
        PH_PG0   = 4'd5,
        PH_PG1   = 4'd6,
        PH_PG2   = 4'd7,
        PH_POST  = 4'd8,
        PH_DONE  = 4'd9
    } phase_t;

    localparam int NUM_PHASES = 10;

    typedef struct packed {
        logic        has_ptr;
        logic [7:0]  ptr_byte;
        logic [7:0]  cmd_byte;
        logic [1:0]  col_n;
        logic [15:0] col_word;
        logic        page_ok;
        logic        page_third;
        logic [23:0] page;
        logic        has_post;
        logic [7:0]  post_byte;
        logic        finish_wait;
    } nccs_desc_t;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
        logic       push;
        logic       pop;
    } nccs_q_stat_t;

endpackage

[rtl/nccs_if.sv]
interface nccs_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  command;
    logic [14:0] column;
    logic        column_valid;
    logic [23:0] page_address;
    logic        page_valid;

    modport source(output valid, command, column, column_valid, page_address, page_valid,
                   input ready);
    modport sink(input valid, command, column, column_valid, page_address, page_valid,
                 output ready);
endinterface

interface nccs_cyc_if;
    logic       valid;
    logic       ready;
    logic [1:0] cycle_kind;
    logic [7:0] bus_byte;
    logic       last;

    modport source(output valid, cycle_kind, bus_byte, last, input ready);
    modport sink(input valid, cycle_kind, bus_byte, last, output ready);
endinterface

[rtl/nand_command_cycle_sequencer.sv]
// nand command cycle sequencer
// req channel: one transfer per request (command, column, page address and
//   their valid flags); cyc channel: one transfer per flash bus cycle, with
//   cycle_kind, bus_byte and last marking the final cycle of a request
// cfg port: cfg_we with cfg_index 0 chip_known, 1 page_shift, 2 chip_shift;
//   write only while no request is in flight
// a request becomes 2 to 9 bus cycles; the back sequencer emits one cycle
//   per clock unless the sink stalls, and the next request follows with no gap
// the first cycle of a request passes the queue entry and the output
//   register before it is presented on cyc
// a two-entry queue parts the classifier from the sequencer, so requests are
//   taken while cycles wait on the sink; with chip_known low a request is
//   taken and yields no cycles
// when the sink stalls the output register holds, the sequencer halts, the
//   queue fills and then req.ready drops
// reset: queue empty, no cycle pending, chip_known 0, page_shift 11,
//   chip_shift 28
module nand_command_cycle_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    nccs_req_if.sink                         req,
    nccs_cyc_if.source                       cyc,
    input  logic                             cfg_we,
    input  logic [nccs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nccs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import nccs_pkg::*;

    nccs_desc_t   wr_desc;
    nccs_desc_t   head;
    nccs_q_stat_t q_stat;
    logic         push;
    logic         pop;

    nccs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_stat.full),
        .push      (push),
        .desc      (wr_desc)
    );

    nccs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_desc (wr_desc),
        .pop     (pop),
        .head    (head),
        .stat    (q_stat)
    );

    nccs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_stat.empty),
        .pop     (pop),
        .cyc     (cyc)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= 2'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("request retired from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cyc.valid && cyc.ready && cyc.last) ##1 (cyc.valid && cyc.ready)
        |-> (cyc.cycle_kind == KIND_WAIT_READY) || $past(cyc.valid && cyc.ready && cyc.last) == 1'b0
        || !$past(cyc.last))
        else $error("request run does not open with wait ready");

    assert property (@(posedge clk) disable iff (!rst_n)
        cyc.valid && ((cyc.cycle_kind == KIND_WAIT_READY) || (cyc.cycle_kind == KIND_WAIT_DONE))
        |-> cyc.bus_byte == 8'h00)
        else $error("wait cycle drives a nonzero byte");
endmodule

[rtl/nccs_front.sv]
module nccs_front (
    input  logic                              clk,
    input  logic                              rst_n,
    nccs_req_if.sink                          req,
    input  logic                              cfg_we,
    input  logic [nccs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [nccs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              q_full,
    output logic                              push,
    output nccs_pkg::nccs_desc_t              desc
);
    import nccs_pkg::*;

    logic       chip_known_reg;
    logic [3:0] page_shift_reg;
    logic [5:0] chip_shift_reg;

    logic        small_mode;
    logic [15:0] psize;
    logic [15:0] col16;
    logic [7:0]  cmd_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_known_reg <= 1'b0;
            page_shift_reg <= 4'd11;
            chip_shift_reg <= 6'd28;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHIP_KNOWN: chip_known_reg <= cfg_data[0];
                CFG_PAGE_SHIFT: page_shift_reg <= cfg_data[3:0];
                CFG_CHIP_SHIFT: chip_shift_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // unknown chip: transfer is taken and dropped
    assign req.ready = !q_full;
    assign push      = req.valid && !q_full && chip_known_reg;

    assign small_mode = page_shift_reg <= SMALL_PAGE_SHIFT_MAX;
    assign psize      = 16'd1 << page_shift_reg;
    assign col16      = {1'b0, req.column};

    always_comb
    begin
        desc             = '0;
        cmd_eff          = req.command;
        desc.col_word    = col16;
        desc.page        = req.page_address;
        desc.page_ok     = req.page_valid;
        desc.ptr_byte    = CMD_READ0;
        desc.post_byte   = CMD_READSTART;
        desc.finish_wait = 1'b1;
        if (small_mode)
        begin
            desc.has_ptr    = req.command == CMD_SEQIN;
            desc.col_n      = req.column_valid ? 2'd1 : 2'd0;
            desc.page_third = chip_shift_reg > SMALL_THIRD_BITS;
            // pointer command picks the area the column falls in
            if (desc.has_ptr && req.column_valid)
            begin
                if (col16 >= psize)
                begin
                    desc.col_word = col16 - psize;
                    desc.ptr_byte = CMD_READOOB;
                end
                else if (col16 >= HALF_POINTER)
                begin
                    desc.col_word = col16 - HALF_POINTER;
                    desc.ptr_byte = CMD_READ1;
                end
            end
            unique case (req.command) inside
                CMD_PAGEPROG, CMD_ERASE1, CMD_ERASE2, CMD_SEQIN, CMD_STATUS:
                    desc.finish_wait = 1'b0;
                default:
                    desc.finish_wait = 1'b1;
            endcase
        end
        else
        begin
            // spare read maps onto read0 past the data area
            if (req.command == CMD_READOOB)
            begin
                cmd_eff       = CMD_READ0;
                desc.col_word = col16 + psize;
            end
            desc.col_n      = req.column_valid ? 2'd2 : 2'd0;
            desc.page_third = chip_shift_reg > LARGE_THIRD_BITS;
            unique case (cmd_eff) inside
                CMD_CACHEDPROG, CMD_PAGEPROG, CMD_ERASE1, CMD_ERASE2, CMD_SEQIN,
                CMD_RNDIN, CMD_STATUS:
                    desc.finish_wait = 1'b0;
                CMD_RNDOUT:
                begin
                    desc.has_post    = 1'b1;
                    desc.post_byte   = CMD_RNDOUTSTART;
                    desc.finish_wait = 1'b0;
                end
                CMD_READ0:
                begin
                    desc.has_post  = 1'b1;
                    desc.post_byte = CMD_READSTART;
                end
                default:
                    desc.finish_wait = 1'b1;
            endcase
        end
        desc.cmd_byte = cmd_eff;
    end
endmodule

[rtl/nccs_queue.sv]
module nccs_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  nccs_pkg::nccs_desc_t   wr_desc,
    input  logic                   pop,
    output nccs_pkg::nccs_desc_t   head,
    output nccs_pkg::nccs_q_stat_t stat
);
    import nccs_pkg::*;

    nccs_desc_t entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign stat.full  = count_reg == 2'(QUEUE_DEPTH);
    assign stat.empty = count_reg == 2'd0;
    assign stat.count = count_reg;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign stat.push  = do_push;
    assign stat.pop   = do_pop;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_desc;
    end
endmodule

[rtl/nccs_back.sv]
module nccs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nccs_pkg::nccs_desc_t head,
    input  logic                 q_empty,
    output logic                 pop,
    nccs_cyc_if.source           cyc
);
    import nccs_pkg::*;

    phase_t     state_reg, state_next;
    phase_t     found;
    logic       any_after;
    logic       advance;
    logic [NUM_PHASES-1:0] present;

    logic       out_valid_reg, out_valid_next;
    kind_t      kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;

    assign advance = !q_empty && (!out_valid_reg || cyc.ready);
    assign pop     = advance && !any_after;

    always_comb
    begin
        present           = '0;
        present[PH_READY] = 1'b1;
        present[PH_PTR]   = head.has_ptr;
        present[PH_CMD]   = 1'b1;
        present[PH_COL0]  = head.col_n != 2'd0;
        present[PH_COL1]  = head.col_n == 2'd2;
        present[PH_PG0]   = head.page_ok;
        present[PH_PG1]   = head.page_ok;
        present[PH_PG2]   = head.page_ok && head.page_third;
        present[PH_POST]  = head.has_post;
        present[PH_DONE]  = head.finish_wait;
    end

    // lowest present phase above the current one
    always_comb
    begin
        found     = PH_READY;
        any_after = 1'b0;
        for (int i = NUM_PHASES - 1; i >= 0; i--)
        begin
            if (present[i] && (4'(i) > state_reg))
            begin
                found     = phase_t'(4'(i));
                any_after = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (advance)
            state_next = any_after ? found : PH_READY;
    end

    always_comb
    begin
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !cyc.ready;
        if (advance)
        begin
            out_valid_next = 1'b1;
            last_next      = !any_after;
            unique case (state_reg)
                PH_READY: begin kind_next = KIND_WAIT_READY; byte_next = 8'h00; end
                PH_PTR:   begin kind_next = KIND_COMMAND; byte_next = head.ptr_byte; end
                PH_CMD:   begin kind_next = KIND_COMMAND; byte_next = head.cmd_byte; end
                PH_COL0:  begin kind_next = KIND_ADDRESS; byte_next = head.col_word[7:0]; end
                PH_COL1:  begin kind_next = KIND_ADDRESS; byte_next = head.col_word[15:8]; end
                PH_PG0:   begin kind_next = KIND_ADDRESS; byte_next = head.page[7:0]; end
                PH_PG1:   begin kind_next = KIND_ADDRESS; byte_next = head.page[15:8]; end
                PH_PG2:   begin kind_next = KIND_ADDRESS; byte_next = head.page[23:16]; end
                PH_POST:  begin kind_next = KIND_COMMAND; byte_next = head.post_byte; end
                PH_DONE:  begin kind_next = KIND_WAIT_DONE; byte_next = 8'h00; end
                default:  begin kind_next = KIND_WAIT_READY; byte_next = 8'h00; end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_READY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign cyc.valid      = out_valid_reg;
    assign cyc.cycle_kind = kind_reg;
    assign cyc.bus_byte   = byte_reg;
    assign cyc.last       = last_reg;
endmodule
